FILE: design/sepq_pkg.sv
// sepq_pkg: shared types and constants for the sorted event priority queue.
// No dependencies.
`timescale 1ns / 1ps

package sepq_pkg;

	localparam int TIME_W = 32;
	localparam int ID_W   = 16;
	localparam int OCC_W  = 7;

	localparam logic ACT_INSERT     = 1'b0;
	localparam logic ACT_REMOVE     = 1'b1;
	localparam logic KIND_ARRIVAL   = 1'b0;
	localparam logic KIND_DEPARTURE = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] evt_time;
		logic              kind;
		logic [ID_W-1:0]   id;
	} entry_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;   // capture input transaction
		logic acc_load;   // update accepted flag
		logic acc_val;
		logic remove;     // drop head: advance head pointer, count - 1
		logic scan_init;  // start tail-to-head walk at count
		logic rd_scan;    // read entry just below scan position
		logic cmp_step;   // place new entry or shift entry up by one
		logic put_head;   // write new entry into head slot
		logic rd_head;    // read entry at head pointer
		logic load_head;  // head register <- read data
		logic out_load;   // load result register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic last;       // exactly one entry stored
		logic scan_zero;  // walk reached the head
		logic ahead;      // read entry stays ahead of new entry
		logic out_busy;   // result register held by sink
	} dp_status_t;

endpackage

FILE: design/sepq_in_if.sv
// sepq_in_if: input channel of the sorted event priority queue.
// Depends on sepq_pkg.
`timescale 1ns / 1ps

interface sepq_in_if;
	logic                          valid;
	logic                          ready;
	logic                          action;
	logic [sepq_pkg::TIME_W-1:0]   event_time;
	logic                          event_kind;
	logic [sepq_pkg::ID_W-1:0]     event_id;

	modport source (output valid, action, event_time, event_kind, event_id, input ready);
	modport sink   (input valid, action, event_time, event_kind, event_id, output ready);
endinterface

FILE: design/sepq_out_if.sv
// sepq_out_if: result channel of the sorted event priority queue.
// Depends on sepq_pkg.
`timescale 1ns / 1ps

interface sepq_out_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [sepq_pkg::OCC_W-1:0]    occupancy;
	logic                          head_valid;
	logic [sepq_pkg::TIME_W-1:0]   head_time;
	logic                          head_kind;
	logic [sepq_pkg::ID_W-1:0]     head_id;

	modport source (output valid, accepted, occupancy, head_valid, head_time, head_kind,
		head_id, input ready);
	modport sink   (input valid, accepted, occupancy, head_valid, head_time, head_kind,
		head_id, output ready);
endinterface

FILE: design/sepq_dp.sv
// sepq_dp: datapath - circular entry memory, head pointer, count, scan counter,
// head register and result register. Depends on sepq_pkg.
`timescale 1ns / 1ps

module sepq_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sepq_pkg::ctrl_cmd_t         cmd,
	output sepq_pkg::dp_status_t        sts,
	input  logic                        action,
	input  logic [sepq_pkg::TIME_W-1:0] event_time,
	input  logic                        event_kind,
	input  logic [sepq_pkg::ID_W-1:0]   event_id,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic                        accepted,
	output logic [sepq_pkg::OCC_W-1:0]  occupancy,
	output logic                        head_valid,
	output logic [sepq_pkg::TIME_W-1:0] head_time,
	output logic                        head_kind,
	output logic [sepq_pkg::ID_W-1:0]   head_id
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_W = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [CW-1:0] ONE_C = CW'(1);

	sepq_pkg::entry_t mem [CAPACITY];
	sepq_pkg::entry_t rd_q;
	sepq_pkg::entry_t new_q;
	sepq_pkg::entry_t head_q;
	sepq_pkg::entry_t out_head_q;
	logic             op_q;
	logic             acc_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    j_q;
	logic [AW-1:0]    head_ptr_q;
	logic             out_valid_q;
	logic             out_acc_q;
	logic [sepq_pkg::OCC_W-1:0] out_occ_q;
	logic             out_hv_q;

	logic [AW-1:0]    a_j;
	logic [AW-1:0]    a_jm1;
	logic [AW-1:0]    a_next_head;
	logic [CW-1:0]    j_m1;
	logic             mem_we;
	logic             mem_re;
	logic [AW-1:0]    waddr;
	logic [AW-1:0]    raddr;
	sepq_pkg::entry_t wdata;
	logic             ahead;

	// physical slot of logical position off (off < CAPACITY)
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= CAP_W)
			sum = sum - CAP_W;
		return sum[AW-1:0];
	endfunction

	assign j_m1        = j_q - ONE_C;
	assign a_j         = phys(head_ptr_q, AW'(j_q));
	assign a_jm1       = phys(head_ptr_q, AW'(j_m1));
	assign a_next_head = phys(head_ptr_q, AW'(ONE_C));

	assign ahead = (rd_q.evt_time < new_q.evt_time) ||
		((new_q.kind == sepq_pkg::KIND_DEPARTURE) && (rd_q.evt_time == new_q.evt_time));

	assign mem_we = cmd.put_head | cmd.cmp_step;
	assign waddr  = cmd.put_head ? head_ptr_q : a_j;
	assign wdata  = (cmd.put_head | ahead) ? new_q : rd_q;
	assign mem_re = cmd.rd_scan | cmd.rd_head;
	assign raddr  = cmd.rd_head ? head_ptr_q : a_jm1;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= wdata;
		if (mem_re)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			head_ptr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.remove) begin
				head_ptr_q <= a_next_head;
				count_q    <= count_q - ONE_C;
			end else if (cmd.put_head || (cmd.cmp_step && ahead)) begin
				count_q <= count_q + ONE_C;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q           <= action;
			new_q.evt_time <= event_time;
			new_q.kind     <= event_kind;
			new_q.id       <= event_id;
		end
		if (cmd.acc_load)
			acc_q <= cmd.acc_val;
		if (cmd.scan_init)
			j_q <= count_q;
		else if (cmd.cmp_step && !ahead)
			j_q <= j_m1;
		if (cmd.put_head)
			head_q <= new_q;
		else if (cmd.load_head)
			head_q <= rd_q;
		if (cmd.out_load) begin
			out_acc_q  <= acc_q;
			out_occ_q  <= sepq_pkg::OCC_W'(count_q);
			out_hv_q   <= (count_q != '0);
			out_head_q <= (count_q != '0) ? head_q : '0;
		end
	end

	assign sts.is_remove = (op_q == sepq_pkg::ACT_REMOVE);
	assign sts.full      = (count_q == CAP_C);
	assign sts.empty     = (count_q == '0);
	assign sts.last      = (count_q == ONE_C);
	assign sts.scan_zero = (j_q == '0);
	assign sts.ahead     = ahead;
	assign sts.out_busy  = out_valid_q & ~out_ready;

	assign out_valid  = out_valid_q;
	assign accepted   = out_acc_q;
	assign occupancy  = out_occ_q;
	assign head_valid = out_hv_q;
	assign head_time  = out_head_q.evt_time;
	assign head_kind  = out_head_q.kind;
	assign head_id    = out_head_q.id;

endmodule

FILE: design/sepq_ctrl.sv
// sepq_ctrl: operation sequencer for the sorted event priority queue.
// Depends on sepq_pkg.
`timescale 1ns / 1ps

module sepq_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  sepq_pkg::dp_status_t   sts,
	output sepq_pkg::ctrl_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_RD,
		S_CMP,
		S_HRD,
		S_HLD,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.acc_load = 1'b1;
				if (sts.is_remove) begin
					if (sts.empty) begin
						cmd.acc_val = 1'b0;
						state_d     = S_DONE;
					end else begin
						cmd.acc_val = 1'b1;
						cmd.remove  = 1'b1;
						state_d     = sts.last ? S_DONE : S_HRD;
					end
				end else begin
					if (sts.full) begin
						cmd.acc_val = 1'b0;
						state_d     = S_DONE;
					end else begin
						cmd.acc_val   = 1'b1;
						cmd.scan_init = 1'b1;
						state_d       = S_RD;
					end
				end
			end
			S_RD: begin
				if (sts.scan_zero) begin
					cmd.put_head = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_scan = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp_step = 1'b1;
				state_d      = sts.ahead ? S_DONE : S_RD;
			end
			S_HRD: begin
				cmd.rd_head = 1'b1;
				state_d     = S_HLD;
			end
			S_HLD: begin
				cmd.load_head = 1'b1;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: design/sorted_event_priority_queue.sv
// sorted_event_priority_queue: top level, bounded sorted queue of timed events.
// Depends on sepq_pkg, sepq_in_if, sepq_out_if, sepq_ctrl, sepq_dp.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+----------------------------------------------
//  in_ch    | in  | valid/ready       | action, event_time, event_kind, event_id
//  out_ch   | out | valid/ready       | accepted, occupancy, head_valid, head_time,
//           |     |                   | head_kind, head_id
//
//  One transaction in, one result transaction out, one operation at a time.
//  Insert: every entry that ends up behind the new one (at most CAPACITY-1) is
//  moved up one slot, and each moved entry costs a read and a write on the
//  one-port store; a new head is written straight into the head slot.
//  Removal reloads the head copy from the store unless it empties the queue.
//  Reset clears count, head pointer and result valid; store contents are left as is.
//  A stalled result stays in the output register; the next transaction is taken
//  while it waits, and its result is loaded once the register frees up.
//
// Entries live in a circular buffer: removal just advances the head pointer,
// insert walks from the tail toward the head shifting entries up one slot until
// the new entry's place is found. A copy of the head entry sits in a register so
// the result never waits on a memory read.

module sorted_event_priority_queue #(
	parameter int CAPACITY = 64
) (
	input logic          clk,
	input logic          arst_n,
	sepq_in_if.sink      in_ch,
	sepq_out_if.source   out_ch
);

	sepq_pkg::ctrl_cmd_t  cmd;
	sepq_pkg::dp_status_t sts;
	logic                 in_ready;

	assign in_ch.ready = in_ready;

	sepq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sepq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (in_ch.action),
		.event_time (in_ch.event_time),
		.event_kind (in_ch.event_kind),
		.event_id   (in_ch.event_id),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.accepted   (out_ch.accepted),
		.occupancy  (out_ch.occupancy),
		.head_valid (out_ch.head_valid),
		.head_time  (out_ch.head_time),
		.head_kind  (out_ch.head_kind),
		.head_id    (out_ch.head_id)
	);

endmodule

FILE: tb/tb_sorted_event_priority_queue.sv
// tb_sorted_event_priority_queue: self-checking bench for the sorted event queue.
// A shadow queue predicts each result; bursty input, patterned output stalls.
// Depends on sepq_pkg, sepq_in_if, sepq_out_if and sorted_event_priority_queue.
`timescale 1ns / 1ps

module tb_sorted_event_priority_queue;

	localparam int TIME_W       = sepq_pkg::TIME_W;
	localparam int ID_W         = sepq_pkg::ID_W;
	localparam int OCC_W        = sepq_pkg::OCC_W;
	localparam int CAPACITY     = 64;
	localparam int CLK_HALF     = 4;
	localparam int RANDOM_ITEMS = 1400;
	// Longest single operation is an insert that moves every stored entry.
	localparam int DRAIN_CYCLES = 8 + 2 * CAPACITY;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int MAX_REPORTS  = 10;

	// One input transaction as the driver presents it.
	typedef struct packed {
		logic              action;
		logic [TIME_W-1:0] evt_time;
		logic              kind;
		logic [ID_W-1:0]   id;
	} queue_op_t;

	// One result transaction: accept flag, fill level and a copy of the head.
	typedef struct packed {
		logic             accepted;
		logic [OCC_W-1:0] occupancy;
		logic             head_valid;
		sepq_pkg::entry_t head;
	} queue_status_t;

	// Receiver behavior; a new mode is picked at random when the current stretch ends.
	typedef enum logic [1:0] {RX_OPEN, RX_THIRD, RX_COIN, RX_HOLD} rx_mode_t;
	// Shape of one stretch of random stimulus.
	typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_MIX} seg_kind_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sepq_in_if  in_if();
	sepq_out_if out_if();

	sorted_event_priority_queue #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	// Stimulus not yet presented, the transaction on the bus, the predicted
	// queue contents (head at index 0) and the results still owed by the DUT.
	queue_op_t        pending_ops[$];
	queue_op_t        on_bus;
	sepq_pkg::entry_t shadow_q[$];
	queue_status_t    expected_status[$];

	int unsigned gap_left, burst_left;
	rx_mode_t    rx_mode;
	int unsigned rx_left, rx_tick;
	int unsigned cycle_count;

	// Coverage tallies and failure counters.
	int unsigned n_ins_ok, n_ins_full, n_rem_ok, n_rem_empty, peak_occ;
	int unsigned n_checked, n_mismatch, n_orphan;

	queue_status_t got, want;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_insert(input logic [TIME_W-1:0] t, input logic k,
		input logic [ID_W-1:0] id);
		pending_ops.push_back('{sepq_pkg::ACT_INSERT, t, k, id});
	endtask

	// Payload of a removal is don't-care for the DUT; fill it with noise so
	// the ignore path sees every bit toggle.
	task automatic add_remove();
		pending_ops.push_back('{sepq_pkg::ACT_REMOVE, TIME_W'($urandom()),
			1'($urandom_range(0, 1)), ID_W'($urandom())});
	endtask

	// Time keys: mostly a narrow range so ties are common, plus both ends of
	// the full 32-bit range.
	function automatic logic [TIME_W-1:0] pick_time();
		case ($urandom_range(0, 4))
			0, 1:    return TIME_W'($urandom_range(0, 7));
			2:       return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 3));
			3:       return TIME_W'($urandom_range(0, 255));
			default: return TIME_W'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Shadow queue: applies one accepted transaction and returns the result
	// the DUT must produce for it. Equal-time rule: a new arrival lands ahead
	// of every entry with its time, a new departure behind all of them.
	// ------------------------------------------------------------------
	function automatic queue_status_t step_shadow_queue(queue_op_t op);
		queue_status_t    st;
		sepq_pkg::entry_t e;
		int               pos;
		st = '0;
		if (op.action == sepq_pkg::ACT_INSERT) begin
			if (shadow_q.size() < CAPACITY) begin
				pos = 0;
				while (pos < shadow_q.size() && (shadow_q[pos].evt_time < op.evt_time ||
					(op.kind == sepq_pkg::KIND_DEPARTURE &&
					shadow_q[pos].evt_time == op.evt_time)))
					pos++;
				e.evt_time = op.evt_time;
				e.kind     = op.kind;
				e.id       = op.id;
				shadow_q.insert(pos, e);
				st.accepted = 1'b1;
				n_ins_ok++;
			end else begin
				n_ins_full++;
			end
		end else begin
			if (shadow_q.size() > 0) begin
				void'(shadow_q.pop_front());
				st.accepted = 1'b1;
				n_rem_ok++;
			end else begin
				n_rem_empty++;
			end
		end
		if (shadow_q.size() > peak_occ)
			peak_occ = shadow_q.size();
		st.occupancy = OCC_W'(shadow_q.size());
		// Empty queue reports an all-zero head.
		if (shadow_q.size() > 0) begin
			st.head_valid = 1'b1;
			st.head       = shadow_q[0];
		end
		return st;
	endfunction

	// ------------------------------------------------------------------
	// Driver: presents pending transactions in bursts with idle gaps. The
	// prediction is taken at the accepting edge so the shadow queue follows
	// the DUT's order exactly.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid      <= 1'b0;
			in_if.action     <= sepq_pkg::ACT_INSERT;
			in_if.event_time <= '0;
			in_if.event_kind <= sepq_pkg::KIND_ARRIVAL;
			in_if.event_id   <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (in_if.valid && in_if.ready)
				expected_status.push_back(step_shadow_queue(on_bus));
			if (!in_if.valid || in_if.ready) begin
				if (gap_left > 0 || pending_ops.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_if.valid <= 1'b0;
				end else begin
					on_bus = pending_ops.pop_front();
					in_if.valid      <= 1'b1;
					in_if.action     <= on_bus.action;
					in_if.event_time <= on_bus.evt_time;
					in_if.event_kind <= on_bus.kind;
					in_if.event_id   <= on_bus.id;
					if (burst_left > 0)
						burst_left--;
					// End of burst: pick the next burst and the gap before it;
					// about a quarter of bursts run back to back.
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready follows a mode that changes every stretch of cycles:
	// always open, one cycle in three, coin flip, or a solid stall.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_left = 0;
			rx_tick = 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = (rx_mode == RX_HOLD) ? $urandom_range(4, 30) : $urandom_range(10, 80);
			end
			rx_left--;
			rx_tick++;
			case (rx_mode)
				RX_OPEN:  out_if.ready <= 1'b1;
				RX_THIRD: out_if.ready <= (rx_tick % 3 == 0);
				RX_COIN:  out_if.ready <= 1'($urandom_range(0, 1));
				default:  out_if.ready <= 1'b0;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every result transaction is matched against the oldest
	// prediction, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			got.accepted      = out_if.accepted;
			got.occupancy     = out_if.occupancy;
			got.head_valid    = out_if.head_valid;
			got.head.evt_time = out_if.head_time;
			got.head.kind     = out_if.head_kind;
			got.head.id       = out_if.head_id;
			if (expected_status.size() == 0) begin
				n_orphan++;
				$display("unexpected result transaction at cycle %0d", cycle_count);
			end else begin
				want = expected_status.pop_front();
				n_checked++;
				if (got.accepted !== want.accepted || got.occupancy !== want.occupancy ||
					got.head_valid !== want.head_valid ||
					got.head.evt_time !== want.head.evt_time ||
					got.head.kind !== want.head.kind || got.head.id !== want.head.id) begin
					n_mismatch++;
					if (n_mismatch <= MAX_REPORTS) begin
						$display("mismatch on result %0d: exp acc=%0b occ=%0d hv=%0b t=%h k=%0b id=%h",
							n_checked, want.accepted, want.occupancy, want.head_valid,
							want.head.evt_time, want.head.kind, want.head.id);
						$display("                        got acc=%0b occ=%0d hv=%0b t=%h k=%0b id=%h",
							got.accepted, got.occupancy, got.head_valid,
							got.head.evt_time, got.head.kind, got.head.id);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_status.size());
			$display("sorted_event_priority_queue test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus build, reset, and end of run.
	// ------------------------------------------------------------------
	initial begin
		seg_kind_t   seg;
		int unsigned n_built, len, ins_pct, i;

		in_if.valid      = 1'b0;
		in_if.action     = sepq_pkg::ACT_INSERT;
		in_if.event_time = '0;
		in_if.event_kind = sepq_pkg::KIND_ARRIVAL;
		in_if.event_id   = '0;
		out_if.ready     = 1'b0;
		cycle_count = 0;
		n_ins_ok = 0; n_ins_full = 0; n_rem_ok = 0; n_rem_empty = 0; peak_occ = 0;
		n_checked = 0; n_mismatch = 0; n_orphan = 0;

		// Directed: removal from empty, ties at one time from both kinds,
		// new head at time zero, both ends of time and id, then drain past empty.
		add_remove();
		add_insert(32'd100, sepq_pkg::KIND_ARRIVAL, 16'h0000);
		add_insert(32'd100, sepq_pkg::KIND_DEPARTURE, 16'hFFFF); // behind the t=100 arrival
		add_insert(32'd100, sepq_pkg::KIND_ARRIVAL, 16'h0001);   // ahead of both
		add_insert(32'd0, sepq_pkg::KIND_DEPARTURE, 16'h0002);   // new head
		add_insert(32'd0, sepq_pkg::KIND_ARRIVAL, 16'h0003);     // arrival takes head on tie
		add_insert(32'hFFFF_FFFF, sepq_pkg::KIND_DEPARTURE, 16'h0004);
		add_insert(32'hFFFF_FFFF, sepq_pkg::KIND_ARRIVAL, 16'h0005);
		add_insert(32'd0, sepq_pkg::KIND_DEPARTURE, 16'h0006);   // last of the t=0 group
		add_insert(32'h8000_0000, sepq_pkg::KIND_ARRIVAL, 16'hAAAA);
		add_insert(32'h5555_5555, sepq_pkg::KIND_DEPARTURE, 16'h5555);
		for (i = 0; i < 12; i++)
			add_remove();                                  // last two are refused

		// Random: fill and drain stretches drive the queue through full and
		// empty repeatedly; mixed stretches churn the middle.
		n_built = 0;
		seg     = SEG_FILL;
		while (n_built < RANDOM_ITEMS) begin
			case (seg)
				SEG_FILL:  begin len = $urandom_range(80, 110); ins_pct = 92; end
				SEG_DRAIN: begin len = $urandom_range(80, 110); ins_pct = 8;  end
				default:   begin len = $urandom_range(20, 60);  ins_pct = 50; end
			endcase
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 99) < ins_pct)
					add_insert(pick_time(), 1'($urandom_range(0, 1)), ID_W'($urandom()));
				else
					add_remove();
			end
			n_built += len;
			seg = seg_kind_t'($urandom_range(0, 2));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_if.valid || expected_status.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d inserts (%0d refused on full) and %0d removals (%0d refused on empty)",
			n_ins_ok + n_ins_full, n_ins_full, n_rem_ok + n_rem_empty, n_rem_empty);
		$display("checked %0d results, peak occupancy %0d, %0d mismatched, %0d unexpected",
			n_checked, peak_occ, n_mismatch, n_orphan);
		if (n_mismatch == 0 && n_orphan == 0 && expected_status.size() == 0) begin
			$display("sorted_event_priority_queue test passed");
		end else begin
			$display("sorted_event_priority_queue test failed");
		end
		$finish;
	end

endmodule

FILE: sorted_event_priority_queue.f
design/sepq_pkg.sv
design/sepq_in_if.sv
design/sepq_out_if.sv
design/sepq_dp.sv
design/sepq_ctrl.sv
design/sorted_event_priority_queue.sv
tb/tb_sorted_event_priority_queue.sv
